[rtl/core/ehse_pkg.sv]
// Shared types and constants for the encoder history speed estimator.
`timescale 1ns / 1ps
package ehse_pkg;

  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd3;

  localparam int SCALE_BITS = 40;
  localparam int SUM_BITS   = 48;
  localparam int SPEED_BITS = 24;
  localparam logic [23:0] PEAK_RESET = 24'd17920;
  localparam logic [23:0] SPEED_MAX  = 24'hFFFFFF;
  localparam logic [7:0]  DEAD_RESET = 8'd50;
  localparam logic [7:0]  LOW_RESET  = 8'd100;
  localparam logic [7:0]  DEAD_STEP  = 8'd5;
  localparam logic [7:0]  LOW_OFFSET = 8'd50;
  localparam logic [7:0]  PWM_HIGH   = 8'd230;
  localparam int MERGE_GAP = 10;
  // ceil(2^30 / 5); exact x/5 for x below 2^30
  localparam logic [27:0] RECIP5_Q30 = 28'd214748365;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_STALL  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_PAIR, S_DIV, S_ACC, S_MEAN_START, S_MEAN_DIV,
    S_PEAK_START, S_PEAK_DIV, S_FINISH, S_OUT
  } state_t;

  typedef struct packed {
    logic start;      // latch input, begin item
    logic load_pair;  // fetch pair at current step
    logic div_start;  // start divider with current operands
    logic div_mode;   // 0 scale/dt, 1 sum/valid
    logic peak_mode;  // latch peak average
    logic acc;        // accumulate pair quotient
    logic merge;      // merge pair into working copy
    logic step;       // advance walk index
    logic finish;     // commit state updates
    logic show;       // present output beat
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic walk_done;  // walk ended (window or last step)
    logic pair_far;   // pair wider than merge gap
    logic div_busy;
    logic any_valid;
    logic mean_gt_peak;
    logic pwm_high;
  } stat_t;

endpackage

[rtl/core/ehse_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ehse_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] rem;
  logic [W-1:0] dsr;
  logic [CW-1:0] cnt;
  logic [W:0] trial;

  always_comb trial = {rem, quotient[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quotient[W-1]};
        quotient <= {quotient[W-2:0], 1'b0};
      end
    end
  end
endmodule

[rtl/core/ehse_ctrl.sv]
// Sequencer for edge, tick and clear items.
`timescale 1ns / 1ps
module ehse_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          out_ready,
  input  ehse_pkg::stat_t stat,
  output ehse_pkg::cmd_t  cmd,
  output logic          in_ready,
  output logic          out_valid
);
  import ehse_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) state_next = (stat.opcode == OP_TICK) ? S_LOAD : S_FINISH;
      S_LOAD: state_next = S_PAIR;
      S_PAIR: begin
        if (stat.walk_done) state_next = S_MEAN_START;
        else if (stat.pair_far) state_next = S_DIV;
        else state_next = S_LOAD;
      end
      S_DIV: if (!stat.div_busy) state_next = S_ACC;
      S_ACC: state_next = S_LOAD;
      S_MEAN_START: state_next = stat.any_valid ? S_MEAN_DIV : S_FINISH;
      S_MEAN_DIV: if (!stat.div_busy) state_next = S_PEAK_START;
      S_PEAK_START: state_next = S_PEAK_DIV;
      S_PEAK_DIV: if (!stat.div_busy) state_next = S_FINISH;
      S_FINISH: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_fire;
      end
      S_LOAD: cmd.load_pair = 1'b1;
      S_PAIR: begin
        if (!stat.walk_done) begin
          cmd.div_start = stat.pair_far;
          cmd.merge = !stat.pair_far;
          cmd.step = !stat.pair_far;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        cmd.step = 1'b1;
      end
      S_MEAN_START: begin
        cmd.div_start = stat.any_valid;
        cmd.div_mode = 1'b1;
      end
      S_PEAK_START: cmd.peak_mode = !stat.mean_gt_peak && stat.pwm_high;
      S_FINISH: cmd.finish = 1'b1;
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

[rtl/core/ehse_dp.sv]
// Entry ring, pair walk, accumulators and result registers.
`timescale 1ns / 1ps
module ehse_dp #(
  parameter int DEPTH = 16,
  parameter int TW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  ehse_pkg::cmd_t  cmd,
  output ehse_pkg::stat_t stat,
  input  logic [1:0]      in_opcode,
  input  logic [TW-1:0]   in_time,
  input  logic            in_forward,
  input  logic [7:0]      in_pwm,
  input  logic [39:0]     rpm_scale,
  input  logic [TW-1:0]   speed_window,
  input  logic [TW-1:0]   stall_timeout,
  output logic [23:0]     speed_rpm,
  output logic [23:0]     peak_rpm,
  output logic [3:0]      valid_samples,
  output logic [31:0]     position_count,
  output logic            stalled,
  output logic [7:0]      dead_zone_pwm,
  output logic [7:0]      low_speed_pwm
);
  import ehse_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = (TW > SUM_BITS) ? TW : SUM_BITS;

  // ring in flip-flops; working copy for merges
  logic [TW-1:0] e_time [DEPTH];
  logic [1:0]    e_dir  [DEPTH];
  logic [7:0]    e_pwm  [DEPTH];
  logic [TW-1:0] w_time [DEPTH];
  logic [1:0]    w_dir  [DEPTH];
  logic [7:0]    w_pwm  [DEPTH];
  logic [AW-1:0] wslot;

  logic [1:0]    op;
  logic [TW-1:0] now;
  logic          fwd;
  logic [7:0]    pwm;
  logic [CW-1:0] s;
  logic [AW-1:0] pi, pj;
  logic [TW-1:0] ti, tj;
  logic [1:0]    di;
  logic [7:0]    pwi;
  logic          in_win;
  logic [TW-1:0] dt;
  logic signed [SUM_BITS-1:0] sum;
  logic [SUM_BITS-1:0] pwm_sum;
  logic [CW-1:0] valid;
  logic [SUM_BITS-1:0] mag;
  logic [23:0]   mean, peak;
  logic [7:0]    dz, ls;
  logic [31:0]   tcount;

  logic          dv_start, dv_busy;
  logic [DW-1:0] dv_a, dv_b, dv_q;
  logic [DW-1:0] pwm_q;

  ehse_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .busy(dv_busy), .quotient(dv_q)
  );

  // newer and older slot of the pair at walk step s
  always_comb begin
    pi = AW'(wslot - AW'(s));
    pj = AW'(wslot - AW'(s) - 1'b1);
  end

  logic [TW-1:0] age;
  always_comb begin
    age = now - ti;
    dt = ti - tj;
    in_win = (age <= speed_window);
    mag = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
  end

  // peak average (19*peak + mean) / 20 as ((x >> 2) * RECIP5_Q30) >> 30,
  // a 27 x 28 bit product
  logic [28:0]   peak_x19;
  logic [54:0]   peak_prod;
  logic [23:0]   peak_avg;
  always_comb begin
    peak_x19 = ({5'd0, peak} << 4) + ({5'd0, peak} << 1) + {5'd0, peak} + {5'd0, mean};
    peak_prod = 55'(peak_x19[28:2]) * 55'(RECIP5_Q30);
  end

  // divider operands and mode
  logic pend_pwm;  // second mean division (pwm) outstanding
  always_comb begin
    dv_start = cmd.div_start || (pend_pwm && !dv_busy);
    dv_a = DW'(rpm_scale);
    dv_b = DW'(dt);
    if (pend_pwm) begin
      dv_a = DW'(pwm_sum);
      dv_b = DW'(valid);
    end else if (cmd.div_mode) begin
      dv_a = DW'(mag);
      dv_b = DW'(valid);
    end
  end

  logic mean_phase, got_mean;
  logic [DW-1:0] mean_q;
  logic          dz_up;
  logic [7:0]    dz_new;

  always_comb begin
    stat.opcode = in_opcode;
    stat.walk_done = (s >= CW'(DEPTH)) || !in_win;
    stat.pair_far = (dt > TW'(MERGE_GAP));
    // busy also covers the cycle between the two mean divisions
    stat.div_busy = dv_busy || pend_pwm || (mean_phase && !got_mean);
    stat.any_valid = (valid != '0);
    stat.mean_gt_peak = (mean > peak);
    stat.pwm_high = (pwm_q > DW'(PWM_HIGH));
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= in_opcode; now <= in_time; fwd <= in_forward; pwm <= in_pwm;
      w_time <= e_time; w_dir <= e_dir; w_pwm <= e_pwm;
      s <= CW'(1); sum <= '0; pwm_sum <= '0; valid <= '0;
      mean <= '0; got_mean <= 1'b0; mean_phase <= 1'b0;
    end
    if (cmd.load_pair) begin
      ti <= w_time[pi]; tj <= w_time[pj]; di <= w_dir[pi]; pwi <= w_pwm[pi];
    end
    if (cmd.merge) begin
      w_time[pj] <= ti; w_dir[pj] <= di; w_pwm[pj] <= pwi;
    end
    if (cmd.step) s <= s + 1'b1;
    if (cmd.acc) begin
      if (di == DIR_FWD) sum <= sum + $signed(SUM_BITS'(dv_q));
      else if (di == DIR_REV) sum <= sum - $signed(SUM_BITS'(dv_q));
      pwm_sum <= pwm_sum + SUM_BITS'(pwi);
      valid <= valid + 1'b1;
    end
    if (cmd.div_start && cmd.div_mode && !cmd.peak_mode) mean_phase <= 1'b1;
    if (mean_phase && !dv_busy && !pend_pwm && !got_mean) begin
      mean_q <= dv_q;
      got_mean <= 1'b1;
    end
    if (pend_pwm && !dv_busy) pwm_q <= '0;
    if (got_mean && mean_phase && !dv_busy && !pend_pwm) begin
      pwm_q <= dv_q;
      mean_phase <= 1'b0;
      mean <= (mean_q > DW'(SPEED_MAX)) ? SPEED_MAX : mean_q[23:0];
    end
    if (cmd.peak_mode) peak_avg <= peak_prod[53:30];
  end

  always_ff @(posedge clk) begin
    if (rst) pend_pwm <= 1'b0;
    else if (pend_pwm && !dv_busy) pend_pwm <= 1'b0;
    else if (mean_phase && !dv_busy && !got_mean) pend_pwm <= 1'b1;
  end

  // state commit
  logic [AW-1:0] last;
  logic          stall_hit;
  always_comb begin
    last = wslot - 1'b1;
    stall_hit = ((now - e_time[last]) >= stall_timeout);
    dz_up = pwm > dz;
    dz_new = (dz >= DEAD_STEP) ? dz - DEAD_STEP : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        e_time[k] <= '0; e_dir[k] <= DIR_NONE; e_pwm[k] <= '0;
      end
      wslot <= '0; tcount <= '0; peak <= PEAK_RESET;
      dz <= DEAD_RESET; ls <= LOW_RESET;
    end else if (cmd.finish) begin
      speed_rpm <= '0; valid_samples <= '0; stalled <= 1'b0;
      case (op)
        OP_EDGE: begin
          e_time[wslot] <= now; e_dir[wslot] <= fwd ? DIR_FWD : DIR_REV;
          e_pwm[wslot] <= pwm; wslot <= wslot + 1'b1;
          tcount <= fwd ? tcount + 32'd1 : tcount - 32'd1;
        end
        OP_TICK: begin
          speed_rpm <= mean;
          valid_samples <= (valid > CW'(15)) ? 4'd15 : 4'(valid);
          if (valid != '0) begin
            if (mean > peak) peak <= mean;
            else if (pwm_q > DW'(PWM_HIGH)) peak <= peak_avg;
          end
          if (stall_hit) begin
            e_time[wslot] <= now; e_dir[wslot] <= DIR_NONE;
            e_pwm[wslot] <= pwm; wslot <= wslot + 1'b1;
            stalled <= 1'b1;
            if (dz_up) begin
              dz <= pwm;
              ls <= ({1'b0, pwm} + 9'd50 > 9'd255) ? 8'd255 : pwm + LOW_OFFSET;
            end
          end else if (pwm < ls) begin
            dz <= dz_new;
            ls <= ({1'b0, dz_new} + 9'd50 > 9'd255) ? 8'd255 : dz_new + LOW_OFFSET;
          end
        end
        OP_CLEAR: begin
          tcount <= '0;
          for (int k = 0; k < DEPTH; k++) begin
            e_time[k] <= '0; e_dir[k] <= DIR_NONE; e_pwm[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign peak_rpm = peak;
  assign position_count = tcount;
  assign dead_zone_pwm = dz;
  assign low_speed_pwm = ls;
endmodule

[rtl/core/encoder_history_speed_estimator.sv]
// Top level: stream ports, APB registers, sequencer and datapath.
//   channel | dir | handshake             | payload
//   s_axis  | in  | s_axis_tvalid/tready  | tdata {pwm,fwd,time}, tuser opcode
//   m_axis  | out | m_axis_tvalid/tready  | tdata result fields
//   apb     | in  | psel/penable/pready   | rpm_scale, window, stall timeout
// Edge and clear items go from accept straight to S_FINISH and then S_OUT.
// A tick walks up to DEPTH-1 pairs; each far pair goes through the shared
// divider, and the mean needs two more divisions. Reset is synchronous and
// active high.
// One item at a time; a result holds until m_axis_tready.
`timescale 1ns / 1ps
module encoder_history_speed_estimator #(
  parameter int HISTORY_DEPTH = 16,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // time_us[31:0], forward[32], drive_pwm[40:33]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [103:0] m_axis_tdata,  // speed, peak, valid, position, stalled, dz, low
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import ehse_pkg::*;

  logic [39:0] rpm_scale;
  logic [31:0] win, stall_to;
  logic [1:0]  ridx;
  assign ridx = paddr[4:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_scale <= 40'd10971428; win <= 32'd200000; stall_to <= 32'd100000;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_SCALE:  rpm_scale <= pwdata[39:0];
        REG_WINDOW: win <= pwdata[31:0];
        REG_STALL:  stall_to <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SCALE:  prdata = {24'd0, rpm_scale};
      REG_WINDOW: prdata = {32'd0, win};
      REG_STALL:  prdata = {32'd0, stall_to};
      default:    prdata = '0;
    endcase
  end

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;
  logic [1:0] op_hold;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  ehse_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_ready(m_axis_tready),
    .stat(stat), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  logic [23:0] sp, pk;
  logic [3:0]  vs;
  logic [31:0] pc;
  logic        st;
  logic [7:0]  dzp, lsp;

  assign op_hold = s_axis_tuser;

  ehse_dp #(.DEPTH(HISTORY_DEPTH), .TW(TIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_opcode(op_hold), .in_time(TIME_BITS'(s_axis_tdata[31:0])),
    .in_forward(s_axis_tdata[32]), .in_pwm(s_axis_tdata[40:33]),
    .rpm_scale(rpm_scale), .speed_window(TIME_BITS'(win)),
    .stall_timeout(TIME_BITS'(stall_to)),
    .speed_rpm(sp), .peak_rpm(pk), .valid_samples(vs), .position_count(pc),
    .stalled(st), .dead_zone_pwm(dzp), .low_speed_pwm(lsp)
  );

  assign m_axis_tdata = {3'd0, lsp, dzp, st, pc, vs, pk, sp};

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
  a_out_after_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_axis_tvalid) else $error("finish without output");
  a_ready_cfg: assert property (@(posedge clk) pready) else $error("pready low");
`endif
endmodule
